FILE: sv/dacll_pkg.sv
`timescale 1ns / 1ps

package dacll_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [31:0] MS_PER_S              = 32'd1000;
    localparam logic [31:0] ROTATION_FACTOR       = 32'd5;
    localparam logic [31:0] ROT_MS_PER_S          = MS_PER_S * ROTATION_FACTOR;
    localparam logic [31:0] UNIT2_START_OFFSET_MS = 32'd20000;
    localparam logic [11:0] CENTI_PER_TENTH       = 12'd10;

    localparam logic [8:0] SETPOINT_MIN   = 9'd150;
    localparam logic [8:0] SETPOINT_MAX   = 9'd300;
    localparam logic [5:0] BAND_MIN       = 6'd10;
    localparam logic [5:0] BAND_MAX       = 6'd50;
    localparam logic [8:0] SETPOINT_RESET = 9'd200;
    localparam logic [5:0] BAND_RESET     = 6'd20;
    localparam logic [15:0] PROTECT_RESET  = 16'd21;
    localparam logic [15:0] ROTATION_RESET = 16'd100;

    // seconds = (ms * DIV_MUL) >> DIV_SHIFT, exact for ms below WAIT_SAT_MS
    localparam int          WAIT_MS_W  = 26;
    localparam int          DIV_SHIFT  = 36;
    localparam logic [26:0] DIV_MUL    = 27'd68719477;
    localparam logic [31:0] WAIT_SAT_MS = 32'd65536000;
    localparam logic [15:0] WAIT_MAX   = 16'hFFFF;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_AUTO_MODE        = 3'd0,
        CFG_ROTATION_ENABLE  = 3'd1,
        CFG_SETPOINT_TENTHS  = 3'd2,
        CFG_BAND_TENTHS      = 3'd3,
        CFG_PROTECT_SECONDS  = 3'd4,
        CFG_ROTATION_SECONDS = 3'd5
    } cfg_idx_t;

    typedef enum logic [1:0] {
        PH_OFF    = 2'd0,
        PH_WANTED = 2'd1,
        PH_ON     = 2'd2
    } phase_t;

    typedef struct packed {
        logic        auto_mode;
        logic        rotation_enable;
        logic [8:0]  setpoint_tenths;
        logic [5:0]  band_tenths;
        logic [15:0] protect_seconds;
        logic [15:0] rotation_seconds;
    } cfg_t;

    typedef struct packed {
        logic [31:0]        now_ms;
        logic signed [14:0] temp_centi;
        logic               manual_want1;
        logic               manual_want2;
    } item_t;

    // step result handed to the wait stages
    typedef struct packed {
        logic        drive1;
        logic        drive2;
        phase_t      phase1;
        phase_t      phase2;
        logic        both_running;
        logic        next_stop_unit;
        logic [31:0] now_ms;
        logic [31:0] restart1;
        logic [31:0] restart2;
        logic [31:0] swap;
    } mid_t;

endpackage

FILE: sv/dacll_if.sv
`timescale 1ns / 1ps

interface dacll_cmd_if;
    logic               valid;
    logic               ready;
    logic [31:0]        now_ms;
    logic signed [14:0] temp_centi;
    logic               manual_want1;
    logic               manual_want2;

    modport source (
        output valid, now_ms, temp_centi, manual_want1, manual_want2,
        input  ready
    );
    modport sink (
        input  valid, now_ms, temp_centi, manual_want1, manual_want2,
        output ready
    );
endinterface

interface dacll_result_if;
    logic        valid;
    logic        ready;
    logic        drive1;
    logic        drive2;
    logic [1:0]  phase1;
    logic [1:0]  phase2;
    logic [15:0] wait1_s;
    logic [15:0] wait2_s;
    logic [15:0] swap_wait_s;
    logic        both_running;
    logic        next_stop_unit;

    modport source (
        output valid, drive1, drive2, phase1, phase2, wait1_s, wait2_s, swap_wait_s,
               both_running, next_stop_unit,
        input  ready
    );
    modport sink (
        input  valid, drive1, drive2, phase1, phase2, wait1_s, wait2_s, swap_wait_s,
               both_running, next_stop_unit,
        output ready
    );
endinterface

FILE: sv/dacll_update.sv
`timescale 1ns / 1ps

module dacll_update (
    input  logic             clk,
    input  logic             rst_n,
    input  dacll_pkg::cfg_t  cfg,
    input  logic             item_valid,
    input  dacll_pkg::item_t item,
    output logic             item_take,
    output logic             mid_valid,
    output dacll_pkg::mid_t  mid,
    input  logic             mid_take
);

    typedef struct packed {
        dacll_pkg::phase_t phase;
        logic              drive;
        logic [31:0]       restart;
    } unit_t;

    function automatic unit_t unit_step(
        dacll_pkg::phase_t ph,
        logic              want,
        logic [31:0]       restart,
        logic [31:0]       now,
        logic [31:0]       hold_ms
    );
        unit_t r;
        r.phase   = ph;
        r.drive   = 1'b0;
        r.restart = restart;
        case (ph)
            dacll_pkg::PH_OFF:
            begin
                if (want)
                    r.phase = dacll_pkg::PH_WANTED;
            end
            dacll_pkg::PH_WANTED:
            begin
                if (now > restart)
                begin
                    r.phase = dacll_pkg::PH_ON;
                    r.drive = 1'b1;
                end
            end
            dacll_pkg::PH_ON:
            begin
                // drive stays high on the step that stops the unit
                r.drive = 1'b1;
                if (!want)
                begin
                    r.phase   = dacll_pkg::PH_OFF;
                    r.restart = now + hold_ms;
                end
            end
            default:
            begin
                r.phase = dacll_pkg::PH_OFF;
            end
        endcase
        return r;
    endfunction

    logic              started_reg;
    dacll_pkg::phase_t ph1_reg, ph2_reg;
    logic              want1_reg, want2_reg, both_reg, stop_reg;
    logic [31:0]       rt1_reg, rt2_reg, swap_reg;
    logic              mid_valid_reg;
    dacll_pkg::mid_t   mid_reg;

    logic              want1_next, want2_next, both_next, stop_next;
    logic [31:0]       swap_next;
    dacll_pkg::mid_t   mid_next;
    unit_t             u1, u2;

    logic [31:0] prot_ms, prot5_ms, rot_ms, now_rot, hold_ms;
    logic [31:0] rt1_base, rt2_base;
    logic [8:0]  sp_lo, sp_hi;
    logic [11:0] lo_centi, hi_centi;
    logic        cold, hot, fire;

    assign prot_ms  = 32'(cfg.protect_seconds) * dacll_pkg::MS_PER_S;
    assign prot5_ms = 32'(cfg.protect_seconds) * dacll_pkg::ROT_MS_PER_S;
    assign rot_ms   = 32'(cfg.rotation_seconds) * dacll_pkg::MS_PER_S;
    assign now_rot  = item.now_ms + rot_ms;

    // setpoint and band are clamped, so both band edges are positive
    assign sp_lo    = cfg.setpoint_tenths - 9'(cfg.band_tenths);
    assign sp_hi    = cfg.setpoint_tenths + 9'(cfg.band_tenths);
    assign lo_centi = 12'(12'(sp_lo) * dacll_pkg::CENTI_PER_TENTH);
    assign hi_centi = 12'(12'(sp_hi) * dacll_pkg::CENTI_PER_TENTH);
    assign cold = item.temp_centi[14] || (item.temp_centi[13:0] < 14'(lo_centi));
    assign hot  = !item.temp_centi[14] && (item.temp_centi[13:0] > 14'(hi_centi));

    assign rt1_base = started_reg ? rt1_reg : prot_ms;
    assign rt2_base = started_reg ? rt2_reg : prot_ms + dacll_pkg::UNIT2_START_OFFSET_MS;

    always_comb
    begin
        want1_next = want1_reg;
        want2_next = want2_reg;
        both_next  = both_reg;
        stop_next  = stop_reg;
        swap_next  = started_reg ? swap_reg : rot_ms;
        hold_ms    = prot_ms;
        if (cfg.auto_mode)
        begin
            if (cold && both_next)
            begin
                if (!stop_next)
                    want1_next = 1'b0;
                else
                    want2_next = 1'b0;
                if (cfg.rotation_enable)
                    stop_next = !stop_next;
                both_next = 1'b0;
                swap_next = now_rot;
            end
            if (hot)
            begin
                want1_next = 1'b1;
                want2_next = 1'b1;
                both_next  = 1'b1;
            end
            if (!both_next && cfg.rotation_enable)
            begin
                if (item.now_ms > swap_next)
                begin
                    // a swap stop holds the unit off five times longer
                    hold_ms    = prot5_ms;
                    want1_next = stop_next;
                    want2_next = !stop_next;
                    stop_next  = !stop_next;
                    swap_next  = now_rot;
                end
            end
            else
            begin
                swap_next = '0;
            end
        end
        else
        begin
            want1_next = item.manual_want1;
            want2_next = item.manual_want2;
        end

        u1 = unit_step(ph1_reg, want1_next, rt1_base, item.now_ms, hold_ms);
        u2 = unit_step(ph2_reg, want2_next, rt2_base, item.now_ms, hold_ms);

        mid_next.drive1         = u1.drive;
        mid_next.drive2         = u2.drive;
        mid_next.phase1         = u1.phase;
        mid_next.phase2         = u2.phase;
        mid_next.both_running   = both_next;
        mid_next.next_stop_unit = stop_next;
        mid_next.now_ms         = item.now_ms;
        mid_next.restart1       = u1.restart;
        mid_next.restart2       = u2.restart;
        mid_next.swap           = swap_next;
    end

    assign item_take = !mid_valid_reg || mid_take;
    assign fire      = item_valid && item_take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg   <= 1'b0;
            ph1_reg       <= dacll_pkg::PH_OFF;
            ph2_reg       <= dacll_pkg::PH_OFF;
            want1_reg     <= 1'b0;
            want2_reg     <= 1'b0;
            both_reg      <= 1'b0;
            stop_reg      <= 1'b0;
            rt1_reg       <= '0;
            rt2_reg       <= '0;
            swap_reg      <= '0;
            mid_valid_reg <= 1'b0;
        end
        else
        begin
            if (item_take)
                mid_valid_reg <= item_valid;
            if (fire)
            begin
                started_reg <= 1'b1;
                ph1_reg     <= u1.phase;
                ph2_reg     <= u2.phase;
                want1_reg   <= want1_next;
                want2_reg   <= want2_next;
                both_reg    <= both_next;
                stop_reg    <= stop_next;
                rt1_reg     <= u1.restart;
                rt2_reg     <= u2.restart;
                swap_reg    <= swap_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
            mid_reg <= mid_next;
    end

    assign mid_valid = mid_valid_reg;
    assign mid       = mid_reg;

endmodule

FILE: sv/dacll_wait.sv
`timescale 1ns / 1ps

module dacll_wait (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            mid_valid,
    input  dacll_pkg::mid_t mid,
    output logic            mid_take,
    dacll_result_if.source  result
);

    typedef struct packed {
        logic                           sat;
        logic [dacll_pkg::WAIT_MS_W-1:0] ms;
    } clip_t;

    typedef struct packed {
        logic              drive1;
        logic              drive2;
        dacll_pkg::phase_t phase1;
        dacll_pkg::phase_t phase2;
        logic              both_running;
        logic              next_stop_unit;
        clip_t             w1;
        clip_t             w2;
        clip_t             ws;
    } calc_t;

    typedef struct packed {
        logic              drive1;
        logic              drive2;
        dacll_pkg::phase_t phase1;
        dacll_pkg::phase_t phase2;
        logic [15:0]       wait1_s;
        logic [15:0]       wait2_s;
        logic [15:0]       swap_wait_s;
        logic              both_running;
        logic              next_stop_unit;
    } out_t;

    // remaining ms, zero if already passed, flagged when past the 16-bit seconds range
    function automatic clip_t clip_ms(logic [31:0] deadline, logic [31:0] now);
        clip_t       r;
        logic [31:0] diff;
        diff  = deadline - now;
        r.sat = 1'b0;
        r.ms  = '0;
        if (deadline > now)
        begin
            if (diff >= dacll_pkg::WAIT_SAT_MS)
                r.sat = 1'b1;
            else
                r.ms = diff[dacll_pkg::WAIT_MS_W-1:0];
        end
        return r;
    endfunction

    function automatic logic [15:0] to_seconds(clip_t c);
        logic [dacll_pkg::WAIT_MS_W+26:0] prod;
        prod = (dacll_pkg::WAIT_MS_W+27)'(c.ms) * (dacll_pkg::WAIT_MS_W+27)'(dacll_pkg::DIV_MUL);
        return c.sat ? dacll_pkg::WAIT_MAX : 16'(prod >> dacll_pkg::DIV_SHIFT);
    endfunction

    logic  calc_valid_reg, out_valid_reg;
    calc_t calc_reg, calc_next;
    out_t  out_reg, out_next;
    logic  out_take;

    always_comb
    begin
        calc_next.drive1         = mid.drive1;
        calc_next.drive2         = mid.drive2;
        calc_next.phase1         = mid.phase1;
        calc_next.phase2         = mid.phase2;
        calc_next.both_running   = mid.both_running;
        calc_next.next_stop_unit = mid.next_stop_unit;
        calc_next.w1             = clip_ms(mid.restart1, mid.now_ms);
        calc_next.w2             = clip_ms(mid.restart2, mid.now_ms);
        calc_next.ws             = clip_ms(mid.swap, mid.now_ms);
    end

    always_comb
    begin
        out_next.drive1         = calc_reg.drive1;
        out_next.drive2         = calc_reg.drive2;
        out_next.phase1         = calc_reg.phase1;
        out_next.phase2         = calc_reg.phase2;
        out_next.both_running   = calc_reg.both_running;
        out_next.next_stop_unit = calc_reg.next_stop_unit;
        out_next.wait1_s        = to_seconds(calc_reg.w1);
        out_next.wait2_s        = to_seconds(calc_reg.w2);
        out_next.swap_wait_s    = to_seconds(calc_reg.ws);
    end

    assign out_take = !out_valid_reg || result.ready;
    assign mid_take = !calc_valid_reg || out_take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            calc_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (mid_take)
                calc_valid_reg <= mid_valid;
            if (out_take)
                out_valid_reg <= calc_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mid_take && mid_valid)
            calc_reg <= calc_next;
        if (out_take && calc_valid_reg)
            out_reg <= out_next;
    end

    assign result.valid          = out_valid_reg;
    assign result.drive1         = out_reg.drive1;
    assign result.drive2         = out_reg.drive2;
    assign result.phase1         = out_reg.phase1;
    assign result.phase2         = out_reg.phase2;
    assign result.wait1_s        = out_reg.wait1_s;
    assign result.wait2_s        = out_reg.wait2_s;
    assign result.swap_wait_s    = out_reg.swap_wait_s;
    assign result.both_running   = out_reg.both_running;
    assign result.next_stop_unit = out_reg.next_stop_unit;

endmodule

FILE: sv/dual_ac_lead_lag_controller_top.sv
`timescale 1ns / 1ps

// Channel   Dir  Words                         Handshake
// cmd       in   now_ms, temp_centi, manual_*  valid/ready
// result    out  drives, phases, waits, flags  valid/ready
// cfg_*     in   register index + data         cfg_we, no wait
//
// One word per cycle while result.ready is high; each accepted word passes the input
// register, step register, clip register and divide/output register before result.
// Reset clears all unit state; start-up deadlines load on the first word.
// result.ready low holds the pipeline; empty stages still take words.

module dual_ac_lead_lag_controller_top (
    input  logic                              clk,
    input  logic                              rst_n,
    dacll_cmd_if.sink                         cmd,
    dacll_result_if.source                    result,
    input  logic                              cfg_we,
    input  logic [dacll_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [dacll_pkg::CFG_DATA_W-1:0]  cfg_data
);

    dacll_pkg::cfg_t  cfg_reg;
    logic             in_valid_reg;
    dacll_pkg::item_t in_reg;
    logic             item_take;
    logic             mid_valid, mid_take;
    dacll_pkg::mid_t  mid;
    logic [8:0]       sp_raw;
    logic [5:0]       band_raw;

    assign sp_raw   = cfg_data[8:0];
    assign band_raw = cfg_data[5:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.auto_mode        <= 1'b1;
            cfg_reg.rotation_enable  <= 1'b1;
            cfg_reg.setpoint_tenths  <= dacll_pkg::SETPOINT_RESET;
            cfg_reg.band_tenths      <= dacll_pkg::BAND_RESET;
            cfg_reg.protect_seconds  <= dacll_pkg::PROTECT_RESET;
            cfg_reg.rotation_seconds <= dacll_pkg::ROTATION_RESET;
        end
        else if (cfg_we)
        begin
            case (dacll_pkg::cfg_idx_t'(cfg_index))
                dacll_pkg::CFG_AUTO_MODE:
                    cfg_reg.auto_mode <= cfg_data[0];
                dacll_pkg::CFG_ROTATION_ENABLE:
                    cfg_reg.rotation_enable <= cfg_data[0];
                dacll_pkg::CFG_SETPOINT_TENTHS:
                begin
                    if (sp_raw < dacll_pkg::SETPOINT_MIN)
                        cfg_reg.setpoint_tenths <= dacll_pkg::SETPOINT_MIN;
                    else if (sp_raw > dacll_pkg::SETPOINT_MAX)
                        cfg_reg.setpoint_tenths <= dacll_pkg::SETPOINT_MAX;
                    else
                        cfg_reg.setpoint_tenths <= sp_raw;
                end
                dacll_pkg::CFG_BAND_TENTHS:
                begin
                    if (band_raw < dacll_pkg::BAND_MIN)
                        cfg_reg.band_tenths <= dacll_pkg::BAND_MIN;
                    else if (band_raw > dacll_pkg::BAND_MAX)
                        cfg_reg.band_tenths <= dacll_pkg::BAND_MAX;
                    else
                        cfg_reg.band_tenths <= band_raw;
                end
                dacll_pkg::CFG_PROTECT_SECONDS:
                    cfg_reg.protect_seconds <= cfg_data;
                dacll_pkg::CFG_ROTATION_SECONDS:
                    cfg_reg.rotation_seconds <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    assign cmd.ready = !in_valid_reg || item_take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (cmd.ready)
            in_valid_reg <= cmd.valid;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ready && cmd.valid)
        begin
            in_reg.now_ms       <= cmd.now_ms;
            in_reg.temp_centi   <= cmd.temp_centi;
            in_reg.manual_want1 <= cmd.manual_want1;
            in_reg.manual_want2 <= cmd.manual_want2;
        end
    end

    dacll_update u_update (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .item_valid (in_valid_reg),
        .item       (in_reg),
        .item_take  (item_take),
        .mid_valid  (mid_valid),
        .mid        (mid),
        .mid_take   (mid_take)
    );

    dacll_wait u_wait (
        .clk       (clk),
        .rst_n     (rst_n),
        .mid_valid (mid_valid),
        .mid       (mid),
        .mid_take  (mid_take),
        .result    (result)
    );

endmodule
